// File: rtl/assert_macros.svh
// Assertion macros used by the asserting RTL file, the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Condition that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`endif

// File: rtl/tsps_pkg.sv
// Package: payload types, constants and command word for the pixel sorter.
package tsps_pkg;
	localparam int MaxSegment = 32;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 10;
	localparam logic [CfgIdxW-1:0] REG_START_TH = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_STOP_TH = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MIN_LEN = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_MAX_LEN = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic line_end;
		logic start_chance;
		logic stop_chance;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic out_line_end;
		logic run_last;
	} out_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	// Command from the classifier to the back end, per decided pixel.
	typedef struct packed {
		pixel_t pix;
		logic append;    // append to segment
		logic flush;     // drain sorted segment first, then emit pix
		logic le;        // emitted pixel carries out_line_end
		logic last;      // last command caused by one input word
	} cmd_t;

	function automatic logic [9:0] bright(input pixel_t p);
		bright = 10'(p.red) + 10'(p.green) + 10'(p.blue);
	endfunction
endpackage

// File: rtl/tsps_front.sv
// Front end: holds one pixel back, computes neighbour difference, classifies.
module tsps_front #(
	parameter int MAX_SEG = tsps_pkg::MaxSegment,
	localparam int CntW = $clog2(MAX_SEG + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [9:0] start_th,
	input  logic [9:0] stop_th,
	input  logic [5:0] min_len,
	input  logic [5:0] max_len,
	input  tsps_pkg::in_word_t in_word,
	input  logic in_valid,
	output logic in_ready,
	output tsps_pkg::cmd_t cmd,
	output logic cmd_valid,
	input  logic cmd_ready
);
	tsps_pkg::pixel_t held_q;
	logic [1:0] held_ch_q;
	logic held_v_q;
	logic act_q;
	logic [CntW-1:0] cnt_q;
	// phase 0: decide held pixel; phase 1: decide line-end pixel
	logic phase_q;
	tsps_pkg::pixel_t cur;
	logic [9:0] d;
	logic [5:0] lim;
	logic act_n, endseg;
	logic [1:0] ch;
	tsps_pkg::pixel_t p;
	logic has_next, need_two;

	function automatic logic [8:0] ad(input logic [7:0] a, input logic [7:0] b);
		ad = (a > b) ? 9'(a - b) : 9'(b - a);
	endfunction

	assign cur = '{in_word.red, in_word.green, in_word.blue, in_word.alpha};
	assign d = 10'(ad(held_q.red, cur.red)) + 10'(ad(held_q.green, cur.green))
		+ 10'(ad(held_q.blue, cur.blue));
	assign lim = (max_len > 6'(MAX_SEG)) ? 6'(MAX_SEG) : max_len;
	assign need_two = held_v_q && in_word.line_end;

	always_comb begin
		if (held_v_q && !phase_q) begin
			p = held_q;
			ch = held_ch_q;
			has_next = 1'b1;
		end else begin
			p = cur;
			ch = {in_word.stop_chance, in_word.start_chance};
			has_next = 1'b0;
		end
		act_n = act_q || (ch[0] && has_next && d > start_th);
		endseg = !has_next || (6'(cnt_q) >= lim)
			|| ((6'(cnt_q) > min_len) && (ch[1] || d > stop_th));
		cmd.pix = p;
		cmd.append = act_n && !endseg;
		cmd.flush = act_n && endseg;
		cmd.le = !has_next;
		cmd.last = !(need_two && !phase_q);
	end

	// A command is issued whenever a decision is due for the current word.
	assign cmd_valid = in_valid && (held_v_q || in_word.line_end);
	assign in_ready = (!cmd_valid || cmd_ready) && !(need_two && !phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			held_ch_q <= '0;
			act_q <= 1'b0;
			cnt_q <= '0;
			phase_q <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				if (cmd.append) begin
					act_q <= 1'b1;
					cnt_q <= cnt_q + 1'b1;
				end else begin
					act_q <= 1'b0;
					cnt_q <= '0;
				end
				if (need_two && !phase_q) phase_q <= 1'b1;
			end
			if (in_valid && in_ready) begin
				phase_q <= 1'b0;
				held_v_q <= !in_word.line_end;
				held_ch_q <= {in_word.stop_chance, in_word.start_chance};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) held_q <= cur;
	end
endmodule

// File: rtl/tsps_fifo.sv
// Short command queue between the front and back ends.
module tsps_fifo #(
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  tsps_pkg::cmd_t wr_data,
	input  logic wr_valid,
	output logic wr_ready,
	output tsps_pkg::cmd_t rd_data,
	output logic rd_valid,
	input  logic rd_ready
);
	tsps_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

// File: rtl/tsps_back.sv
// Back end: insertion chain sorts the segment; drains it and emits words.
module tsps_back #(
	parameter int MAX_SEG = tsps_pkg::MaxSegment,
	localparam int CntW = $clog2(MAX_SEG + 1),
	localparam int SegAW = $clog2(MAX_SEG)
) (
	input  logic clk,
	input  logic arst_n,
	input  tsps_pkg::cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_ready,
	output tsps_pkg::out_word_t out_word,
	output logic out_valid,
	input  logic out_ready,
	output logic draining
);
	// Sorted chain: entry 0 is dimmest. Each cell decides locally on insert.
	tsps_pkg::pixel_t chain_q [MAX_SEG];
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] rd_q;
	logic drain_q;
	logic gt [MAX_SEG];
	logic gt_prev [MAX_SEG];
	tsps_pkg::pixel_t prev [MAX_SEG];
	logic [9:0] key;
	logic ov_load, ov_free;
	tsps_pkg::out_word_t ow;

	assign key = tsps_pkg::bright(cmd.pix);
	always_comb begin
		for (int i = 0; i < MAX_SEG; i++)
			gt[i] = tsps_pkg::bright(chain_q[i]) > key;
		// left neighbour of each cell; cell 0 takes the new pixel
		gt_prev[0] = 1'b0;
		prev[0] = cmd.pix;
		for (int i = 1; i < MAX_SEG; i++) begin
			gt_prev[i] = gt[i-1];
			prev[i] = chain_q[i-1];
		end
	end

	assign ov_free = !out_valid || out_ready;
	assign draining = drain_q;
	// Append needs no output; flush first drains the chain, then emits pix.
	assign cmd_ready = cmd_valid && (cmd.append || (ov_free && drain_q == 1'b0
		&& (!cmd.flush || cnt_q == '0 || rd_q == cnt_q)));
	assign ov_load = ov_free && ((drain_q && rd_q != cnt_q)
		|| (cmd_ready && !cmd.append));

	always_comb begin
		if (drain_q && rd_q != cnt_q) begin
			ow = '{chain_q[rd_q[SegAW-1:0]].red, chain_q[rd_q[SegAW-1:0]].green,
				chain_q[rd_q[SegAW-1:0]].blue, chain_q[rd_q[SegAW-1:0]].alpha,
				1'b0, 1'b0};
		end else begin
			ow = '{cmd.pix.red, cmd.pix.green, cmd.pix.blue, cmd.pix.alpha,
				cmd.le, cmd.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			cnt_q <= '0;
			rd_q <= '0;
			drain_q <= 1'b0;
		end else begin
			if (ov_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd_valid && cmd.append && cmd_ready) cnt_q <= cnt_q + 1'b1;
			if (!drain_q && cmd_valid && cmd.flush && cnt_q != '0 && rd_q == '0)
				drain_q <= 1'b1;
			if (drain_q && ov_free) begin
				if (rd_q != cnt_q) rd_q <= rd_q + 1'b1;
				else drain_q <= 1'b0;
			end
			if (cmd_ready && cmd.flush) begin
				cnt_q <= '0;
				rd_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ov_load) out_word <= ow;
		if (cmd_valid && cmd.append && cmd_ready) begin
			for (int i = 0; i < MAX_SEG; i++) begin
				if (CntW'(i) == cnt_q || (CntW'(i) < cnt_q && gt[i])) begin
					if (gt_prev[i]) chain_q[i] <= prev[i];
					else chain_q[i] <= cmd.pix;
				end
			end
		end
	end
endmodule

// File: rtl/threshold_segment_pixel_sorter.sv
// Top level of the threshold segment pixel sorter.
//  channel  | handshake               | payload
//  in       | in_valid / in_ready     | in_word (tsps_pkg::in_word_t)
//  out      | out_valid / out_ready   | out_word (tsps_pkg::out_word_t)
//  cfg      | cfg_we                  | cfg_idx, cfg_data
// Each decided pixel gives one command; a line-end word after a held pixel
// gives two, the held pixel first. A flushing segment starts a drain, reads
// its pixels in order through the single read port of the sorted chain and
// closes the drain before the flush pixel is emitted; joins are absorbed.
// Reset clears all control; the chain needs no clearing pass.
// Either side stalls independently through a two-entry command queue.
`include "assert_macros.svh"
module threshold_segment_pixel_sorter #(
	parameter int MAX_SEGMENT = tsps_pkg::MaxSegment
) (
	input  logic clk,
	input  logic arst_n,
	input  tsps_pkg::in_word_t in_word,
	input  logic in_valid,
	output logic in_ready,
	output tsps_pkg::out_word_t out_word,
	output logic out_valid,
	input  logic out_ready,
	input  logic cfg_we,
	input  logic [tsps_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [tsps_pkg::CfgDataW-1:0] cfg_data
);
	logic [9:0] start_th_q, stop_th_q;
	logic [5:0] min_len_q, max_len_q;
	tsps_pkg::cmd_t f_cmd, b_cmd;
	logic f_v, f_r, b_v, b_r, draining;

	// register file, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_th_q <= '0;
			stop_th_q <= '0;
			min_len_q <= '0;
			max_len_q <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_idx)
				tsps_pkg::REG_START_TH: start_th_q <= cfg_data;
				tsps_pkg::REG_STOP_TH: stop_th_q <= cfg_data;
				tsps_pkg::REG_MIN_LEN: min_len_q <= cfg_data[5:0];
				tsps_pkg::REG_MAX_LEN: max_len_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	tsps_front #(.MAX_SEG(MAX_SEGMENT)) u_front (
		.clk, .arst_n,
		.start_th(start_th_q), .stop_th(stop_th_q),
		.min_len(min_len_q), .max_len(max_len_q),
		.in_word, .in_valid, .in_ready,
		.cmd(f_cmd), .cmd_valid(f_v), .cmd_ready(f_r)
	);

	tsps_fifo #(.DEPTH(2)) u_fifo (
		.clk, .arst_n,
		.wr_data(f_cmd), .wr_valid(f_v), .wr_ready(f_r),
		.rd_data(b_cmd), .rd_valid(b_v), .rd_ready(b_r)
	);

	tsps_back #(.MAX_SEG(MAX_SEGMENT)) u_back (
		.clk, .arst_n,
		.cmd(b_cmd), .cmd_valid(b_v), .cmd_ready(b_r),
		.out_word, .out_valid, .out_ready, .draining
	);

	// output word may not change while stalled
	`ASSERT_IMP(a_out_hold, clk, arst_n, out_valid && !out_ready, ##1 $stable(out_word))
	// queue never pops a join while the chain is draining
	`ASSERT_IMP(a_no_join_drain, clk, arst_n, draining, !(b_r && b_cmd.append))
endmodule

// File: tb/sv/tb_threshold_segment_pixel_sorter.sv
// Testbench for the threshold segment pixel sorter: directed table, random lines, self-checking.
module tb_threshold_segment_pixel_sorter;
	timeunit 1ns;
	timeprecision 1ps;

	// Drain allowance: a full segment flush plus pipeline slack
	localparam int DrainCycles = 2 * tsps_pkg::MaxSegment + 40;

	logic clk;
	logic arst_n;
	tsps_pkg::in_word_t in_word;
	logic in_valid;
	logic in_ready;
	tsps_pkg::out_word_t out_word;
	logic out_valid;
	logic out_ready;
	logic cfg_we;
	logic [tsps_pkg::CfgIdxW-1:0] cfg_idx;
	logic [tsps_pkg::CfgDataW-1:0] cfg_data;

	threshold_segment_pixel_sorter u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_word(in_word), .in_valid(in_valid), .in_ready(in_ready),
		.out_word(out_word), .out_valid(out_valid), .out_ready(out_ready),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---- sorter model state -------------------------------------------
	int unsigned start_th, stop_th, min_len, max_len;
	tsps_pkg::in_word_t held_pix;
	bit held_ok;
	tsps_pkg::in_word_t seg_buf[tsps_pkg::MaxSegment];
	bit seg_open;
	int unsigned seg_n;
	tsps_pkg::out_word_t step_q[$];     // words caused by the current input word
	tsps_pkg::out_word_t sorted_q[$];   // words still owed by the block
	int errors;
	int src_idle, snk_idle;
	int hold_left;

	function automatic int unsigned luma(tsps_pkg::in_word_t p);
		return p.red + p.green + p.blue;
	endfunction

	function automatic int unsigned adiff(logic [7:0] a, logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic tsps_pkg::out_word_t as_out(tsps_pkg::in_word_t p, bit le);
		tsps_pkg::out_word_t o;
		o.out_red = p.red;
		o.out_green = p.green;
		o.out_blue = p.blue;
		o.out_alpha = p.alpha;
		o.out_line_end = le;
		o.run_last = 1'b0;
		return o;
	endfunction

	function automatic tsps_pkg::in_word_t px(int r, int g, int b, int a, bit le, bit sc,
		bit pc);
		tsps_pkg::in_word_t w;
		w.red = 8'(r); w.green = 8'(g); w.blue = 8'(b); w.alpha = 8'(a);
		w.line_end = le; w.start_chance = sc; w.stop_chance = pc;
		return w;
	endfunction

	// Judge one pixel against its right-hand neighbour (none at line end)
	task automatic judge_pixel(tsps_pkg::in_word_t p, bit has_nb, tsps_pkg::in_word_t nb);
		int unsigned d, lim, i, j;
		tsps_pkg::in_word_t v;
		bit close;
		d = has_nb ? adiff(p.red, nb.red) + adiff(p.green, nb.green)
			+ adiff(p.blue, nb.blue) : 0;
		if (!seg_open && p.start_chance && has_nb && d > start_th) begin
			seg_open = 1'b1;
			seg_n = 0;
		end
		if (!seg_open) begin
			step_q.push_back(as_out(p, !has_nb));
			return;
		end
		lim = (max_len > tsps_pkg::MaxSegment) ? tsps_pkg::MaxSegment : max_len;
		close = !has_nb || seg_n >= lim
			|| (seg_n > min_len && (p.stop_chance || d > stop_th));
		if (!close) begin
			seg_buf[seg_n] = p;
			seg_n++;
			return;
		end
		// stable insertion sort, brightest last
		for (i = 1; i < seg_n; i++) begin
			v = seg_buf[i];
			j = i;
			while (j > 0 && luma(seg_buf[j-1]) > luma(v)) begin
				seg_buf[j] = seg_buf[j-1];
				j--;
			end
			seg_buf[j] = v;
		end
		for (i = 0; i < seg_n; i++) step_q.push_back(as_out(seg_buf[i], 1'b0));
		seg_open = 1'b0;
		seg_n = 0;
		step_q.push_back(as_out(p, !has_nb));
	endtask

	// Advance the model by one accepted input word; results land in step_q
	task automatic sort_step(tsps_pkg::in_word_t w);
		step_q.delete();
		if (held_ok) begin
			judge_pixel(held_pix, 1'b1, w);
			held_ok = 1'b0;
		end
		if (w.line_end) judge_pixel(w, 1'b0, w);
		else begin
			held_pix = w;
			held_ok = 1'b1;
		end
		if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
	endtask

	task automatic report_mismatch(string what);
		$display("%0t: mismatch: %s", $realtime, what);
		errors++;
	endtask

	// ---- receiver side: checking and back-pressure --------------------
	initial begin
		tsps_pkg::out_word_t want;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (sorted_q.size() == 0) report_mismatch("word with nothing expected");
				else begin
					want = sorted_q.pop_front();
					if (out_word.out_red !== want.out_red)
						report_mismatch($sformatf("out_red %0h want %0h",
							out_word.out_red, want.out_red));
					if (out_word.out_green !== want.out_green)
						report_mismatch($sformatf("out_green %0h want %0h",
							out_word.out_green, want.out_green));
					if (out_word.out_blue !== want.out_blue)
						report_mismatch($sformatf("out_blue %0h want %0h",
							out_word.out_blue, want.out_blue));
					if (out_word.out_alpha !== want.out_alpha)
						report_mismatch($sformatf("out_alpha %0h want %0h",
							out_word.out_alpha, want.out_alpha));
					if (out_word.out_line_end !== want.out_line_end)
						report_mismatch($sformatf("out_line_end %b want %b",
							out_word.out_line_end, want.out_line_end));
					if (out_word.run_last !== want.run_last)
						report_mismatch($sformatf("run_last %b want %b",
							out_word.run_last, want.run_last));
				end
			end
			// long hold-off so the command queue fills and in_ready drops
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else out_ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// ---- sender side ---------------------------------------------------
	task automatic send_word(tsps_pkg::in_word_t w, bit typed,
		tsps_pkg::out_word_t typed_want);
		int gap;
		if ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			gap = $urandom_range(4, 1);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		sort_step(w);
		// typed rows: model still advances, expectation is the hand-written one
		if (typed) sorted_q.push_back(typed_want);
		else foreach (step_q[k]) sorted_q.push_back(step_q[k]);
	endtask

	// Register writes only happen with the block idle
	task automatic set_regs(int unsigned s_th, int unsigned p_th, int unsigned mn,
		int unsigned mx);
		int unsigned vals[4];
		logic [tsps_pkg::CfgIdxW-1:0] idx[4];
		vals = '{s_th, p_th, mn, mx};
		idx = '{tsps_pkg::REG_START_TH, tsps_pkg::REG_STOP_TH, tsps_pkg::REG_MIN_LEN,
			tsps_pkg::REG_MAX_LEN};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_idx <= idx[k];
			cfg_data <= vals[k][tsps_pkg::CfgDataW-1:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		start_th = s_th & 10'h3FF;
		stop_th = p_th & 10'h3FF;
		min_len = mn & 6'h3F;
		max_len = mx & 6'h3F;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sorted_q.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// One random line: runs of similar colour with occasional jumps
	task automatic random_line(int len);
		int r, g, b, js;
		tsps_pkg::in_word_t w;
		tsps_pkg::out_word_t none;
		none = '0;
		r = $urandom_range(255); g = $urandom_range(255); b = $urandom_range(255);
		for (int k = 0; k < len; k++) begin
			js = ($urandom_range(3) == 0) ? 255 : 12;
			r = (r + $urandom_range(2 * js) - js) & 8'hFF;
			g = (g + $urandom_range(2 * js) - js) & 8'hFF;
			b = (b + $urandom_range(2 * js) - js) & 8'hFF;
			w = px(r, g, b, $urandom_range(255), k == len - 1,
				$urandom_range(2) != 0, $urandom_range(3) == 0);
			send_word(w, 1'b0, none);
		end
	endtask

	typedef struct {
		tsps_pkg::in_word_t w;
		bit typed;
		tsps_pkg::out_word_t want;
	} stim_row_t;

	stim_row_t directed[$];

	initial begin
		tsps_pkg::out_word_t none;
		none = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		errors = 0;
		hold_left = 0;
		src_idle = 33;
		snk_idle = 57;
		start_th = 0; stop_th = 0; min_len = 0; max_len = tsps_pkg::MaxSegment;
		held_ok = 1'b0; seg_open = 1'b0; seg_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at reset settings. Single-pixel lines pass straight
		// through with line end and run_last set.
		directed = '{
			'{px(255, 255, 255, 255, 1, 1, 1), 1, 34'h3_FFFF_FFFF},
			'{px(0, 0, 0, 0, 1, 0, 0), 1, 34'h0_0000_0003},
			// segment opening on the very first pixel, ties kept in order
			'{px(200, 200, 200, 1, 0, 1, 0), 0, none},
			'{px(10, 10, 10, 2, 0, 0, 0), 0, none},
			'{px(10, 10, 10, 3, 0, 0, 0), 0, none},
			'{px(10, 10, 10, 4, 0, 0, 1), 0, none},
			'{px(0, 0, 0, 5, 0, 1, 0), 0, none},
			'{px(255, 0, 255, 6, 0, 1, 0), 0, none},
			'{px(0, 255, 0, 7, 0, 0, 1), 0, none},
			'{px(128, 128, 128, 8, 0, 1, 0), 0, none},
			'{px(128, 128, 128, 9, 1, 1, 1), 0, none},
			'{px(17, 34, 51, 170, 1, 0, 1), 1, {8'd17, 8'd34, 8'd51, 8'd170, 2'b11}},
			// line end closing an open segment
			'{px(255, 255, 255, 10, 0, 1, 0), 0, none},
			'{px(0, 0, 0, 11, 0, 0, 0), 0, none},
			'{px(90, 90, 90, 12, 0, 0, 0), 0, none},
			'{px(1, 2, 3, 13, 1, 0, 0), 0, none}
		};
		foreach (directed[k]) send_word(directed[k].w, directed[k].typed, directed[k].want);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			src_idle = (ph < 2) ? 33 : (ph < 4) ? 57 : 0;
			snk_idle = (ph < 2) ? 57 : (ph < 4) ? 33 : 0;
			case (ph)
				0: set_regs(765, 765, 32, 1);       // extremes: nothing starts
				1: set_regs(0, 765, 0, 0);          // max zero: empty segments
				2: set_regs(60, 120, 2, 8);
				3: set_regs(0, 0, 31, 63);          // saturating max, high min
				4: set_regs($urandom_range(765), $urandom_range(765),
					$urandom_range(32), $urandom_range(32, 1));
				default: set_regs(20, 300, 0, 32);
			endcase
			if (ph == 5) hold_left = 400;           // receiver stalls, sender keeps going
			for (int n = 0; n < 46; ) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) :
					$urandom_range(12, 1);
				random_line(len);
				n += len;
			end
		end

		in_valid <= 1'b0;
		while (sorted_q.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
